// ===== src/ckmb_pkg.sv =====
// Shared types and constants for the color key mask and bounding box block.
`default_nettype none

package ckmb_pkg;

  // Field widths fixed by the register map and stream format
  localparam int unsigned PIX_W     = 32;
  localparam int unsigned FMT_W     = 2;
  localparam int unsigned TOL_W     = 8;
  localparam int unsigned CFG_DIM_W = 13;
  localparam int unsigned BOX_W     = 12;
  localparam int unsigned APB_AW    = 5;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned OUT_DW    = 56;

  localparam int unsigned MAX_DIM_DEF = 4096;

  // Pixel formats
  localparam logic [FMT_W-1:0] FMT_RGBA  = 2'd0;
  localparam logic [FMT_W-1:0] FMT_GRAY  = 2'd1;
  localparam logic [FMT_W-1:0] FMT_INDEX = 2'd2;

  // Register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_FORMAT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TOL    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 3'd4;

  typedef struct packed {
    logic [FMT_W-1:0] fmt;
    logic [PIX_W-1:0] key;
    logic [TOL_W-1:0] tol;
  } match_cfg_t;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] width;
    logic [CFG_DIM_W-1:0] height;
  } frame_dims_t;

  typedef struct packed {
    logic             mask_bit;
    logic             frame_done;
    logic             box_empty;
    logic [BOX_W-1:0] box_left;
    logic [BOX_W-1:0] box_top;
    logic [BOX_W-1:0] box_right;
    logic [BOX_W-1:0] box_bottom;
  } result_t;

endpackage

`default_nettype wire

// ===== src/ckmb_front.sv =====
// Front end: takes pixel beats, compares them against the key color, stages the mask bit.
`default_nettype none

module ckmb_front import ckmb_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire match_cfg_t       cfg_i,
  input  wire logic             pix_valid_i,
  output logic                  pix_ready_o,
  input  wire logic [PIX_W-1:0] pix_data_i,
  output logic                  q_valid_o,
  input  wire logic             q_ready_i,
  output logic                  q_match_o
);

  logic stg_valid_q, stg_valid_d;
  logic stg_match_q, stg_match_d;
  logic pix_match;

  // |p - k| <= t, done in 9 bits so neither side wraps
  function automatic logic chan_ok(logic [7:0] p, logic [7:0] k, logic [7:0] t);
    logic [8:0] p_up;
    logic [8:0] k_up;
    p_up = {1'b0, p} + {1'b0, t};
    k_up = {1'b0, k} + {1'b0, t};
    return (p_up >= {1'b0, k}) && ({1'b0, p} <= k_up);
  endfunction

  always_comb begin
    unique case (cfg_i.fmt)
      FMT_RGBA: begin
        pix_match = chan_ok(pix_data_i[7:0],   cfg_i.key[7:0],   cfg_i.tol) &&
                    chan_ok(pix_data_i[15:8],  cfg_i.key[15:8],  cfg_i.tol) &&
                    chan_ok(pix_data_i[23:16], cfg_i.key[23:16], cfg_i.tol) &&
                    chan_ok(pix_data_i[31:24], cfg_i.key[31:24], cfg_i.tol);
      end
      FMT_GRAY: begin
        pix_match = chan_ok(pix_data_i[7:0],  cfg_i.key[7:0],  cfg_i.tol) &&
                    chan_ok(pix_data_i[15:8], cfg_i.key[15:8], cfg_i.tol);
      end
      FMT_INDEX: begin
        pix_match = chan_ok(pix_data_i[7:0], cfg_i.key[7:0], cfg_i.tol);
      end
      default: begin
        pix_match = 1'b0;
      end
    endcase
  end

  assign pix_ready_o = !stg_valid_q || q_ready_i;
  assign q_valid_o   = stg_valid_q;
  assign q_match_o   = stg_match_q;

  always_comb begin
    stg_valid_d = stg_valid_q;
    stg_match_d = stg_match_q;
    if (pix_ready_o) begin
      stg_valid_d = pix_valid_i;
      stg_match_d = pix_match;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stg_match_q <= stg_match_d;
  end

  // a staged beat that the queue refuses must sit unchanged
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_valid_q && !q_ready_i |=> stg_valid_q && $stable(stg_match_q))
    else $error("front stage dropped or changed a waiting beat");

endmodule

`default_nettype wire

// ===== src/ckmb_fifo.sv =====
// Two-entry queue between the classifier and the frame tracker.
`default_nettype none

module ckmb_fifo #(
  parameter int unsigned WIDTH = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic [WIDTH-1:0]      pop_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= 2'd2) && ((count_q == 2'd1) == (wr_ptr_q != rd_ptr_q)))
    else $error("queue count and pointers disagree");

endmodule

`default_nettype wire

// ===== src/ckmb_back.sv =====
// Back end: raster counters, bounding box tracking and the result register.
`default_nettype none

module ckmb_back import ckmb_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire frame_dims_t dims_i,
  input  wire logic        q_valid_i,
  output logic             q_ready_o,
  input  wire logic        q_match_i,
  output logic             res_valid_o,
  input  wire logic        res_ready_i,
  output result_t          res_o
);

  localparam int unsigned CW  = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned NW  = $clog2(MAX_DIM + 1);
  localparam int unsigned DW  = (NW > CFG_DIM_W) ? NW : CFG_DIM_W;
  localparam logic [DW-1:0] DIM_MAX = DW'(MAX_DIM);

  logic [CW-1:0] col_q, col_d, row_q, row_d;
  logic [CW-1:0] min_col_q, min_col_d, min_row_q, min_row_d;
  logic [CW-1:0] max_col_q, max_col_d, max_row_q, max_row_d;
  logic          any_q, any_d;
  logic          res_valid_q, res_valid_d;
  result_t       res_q, res_d;
  logic          pop, row_end, done;
  logic [DW-1:0] w_eff, h_eff;

  function automatic logic [DW-1:0] dim_eff(logic [CFG_DIM_W-1:0] d);
    logic [DW-1:0] dx;
    dx = DW'(d);
    if (dx == '0) begin
      return DW'(1);
    end else if (dx > DIM_MAX) begin
      return DIM_MAX;
    end
    return dx;
  endfunction

  assign w_eff   = dim_eff(dims_i.width);
  assign h_eff   = dim_eff(dims_i.height);
  // >= so that counters left past a shrunken frame still close it
  assign row_end = (DW'(col_q) + DW'(1)) >= w_eff;
  assign done    = row_end && ((DW'(row_q) + DW'(1)) >= h_eff);

  assign q_ready_o   = !res_valid_q || res_ready_i;
  assign pop         = q_valid_i && q_ready_o;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    min_col_d   = min_col_q;
    min_row_d   = min_row_q;
    max_col_d   = max_col_q;
    max_row_d   = max_row_q;
    any_d       = any_q;
    res_d       = res_q;
    res_valid_d = res_valid_q;
    if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
    if (pop) begin
      res_valid_d = 1'b1;
      if (q_match_i) begin
        if (!any_q || col_q < min_col_q) min_col_d = col_q;
        if (!any_q || row_q < min_row_q) min_row_d = row_q;
        if (!any_q || col_q > max_col_q) max_col_d = col_q;
        if (!any_q || row_q > max_row_q) max_row_d = row_q;
        any_d = 1'b1;
      end
      res_d            = '0;
      res_d.mask_bit   = q_match_i;
      res_d.frame_done = done;
      if (done) begin
        if (any_d) begin
          res_d.box_left   = BOX_W'(min_col_d);
          res_d.box_top    = BOX_W'(min_row_d);
          res_d.box_right  = BOX_W'(max_col_d);
          res_d.box_bottom = BOX_W'(max_row_d);
        end else begin
          res_d.box_empty = 1'b1;
        end
        col_d     = '0;
        row_d     = '0;
        min_col_d = '1;
        min_row_d = '1;
        max_col_d = '0;
        max_row_d = '0;
        any_d     = 1'b0;
      end else if (row_end) begin
        col_d = '0;
        row_d = CW'(row_q + CW'(1));
      end else begin
        col_d = CW'(col_q + CW'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      min_col_q   <= '1;
      min_row_q   <= '1;
      max_col_q   <= '0;
      max_row_q   <= '0;
      any_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      min_col_q   <= min_col_d;
      min_row_q   <= min_row_d;
      max_col_q   <= max_col_d;
      max_row_q   <= max_row_d;
      any_q       <= any_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && done |=> (col_q == '0) && (row_q == '0) && !any_q)
    else $error("frame end did not restart the counters");

  a_box_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_q |-> (min_col_q <= max_col_q) && (min_row_q <= max_row_q))
    else $error("bounding box corners crossed");

  a_empty_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.box_empty |-> res_q.frame_done)
    else $error("empty box flagged on a beat that is not the frame end");

endmodule

`default_nettype wire

// ===== src/color_key_mask_bbox_top.sv =====
// Top level: register port, classifier front end, queue and frame tracker.
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata = pixel_value
//  m_axis    out  m_axis_tvalid/tready      tdata = mask_bit, box_empty, box fields; tlast = frame_done
//  apb       in   psel/penable/pwrite       5 registers at byte address 4*index
//
//  One pixel beat per clock sustained while m_axis_tready stays high.
//  The front stage and the two-entry queue let pixels flow while a result waits.
//  A stalled result backs up through the queue; s_axis_tready drops once the front
//  stage and both queue slots hold beats.
//  Reset clears frame counters and box; registers return to format RGBA, key 0,
//  tolerance 0, 1x1 frame.
`default_nettype none

module color_key_mask_bbox_top import ckmb_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // pixel_value [31:0]
  input  wire logic [PIX_W-1:0]  s_axis_tdata,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // mask_bit [0], box_empty [1], box_left [13:2], box_top [25:14],
  // box_right [37:26], box_bottom [49:38], zero [55:50]
  output logic [OUT_DW-1:0]      m_axis_tdata,
  output logic                   m_axis_tlast,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  logic [FMT_W-1:0]     fmt_q;
  logic [PIX_W-1:0]     key_q;
  logic [TOL_W-1:0]     tol_q;
  logic [CFG_DIM_W-1:0] width_q;
  logic [CFG_DIM_W-1:0] height_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  match_cfg_t  match_cfg;
  frame_dims_t dims;
  logic        fq_valid, fq_ready, fq_match;
  logic        bq_valid, bq_ready, bq_match;
  result_t     res;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= FMT_RGBA;
      key_q    <= '0;
      tol_q    <= '0;
      width_q  <= CFG_DIM_W'(1);
      height_q <= CFG_DIM_W'(1);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FORMAT: fmt_q    <= pwdata[FMT_W-1:0];
        REG_KEY:    key_q    <= pwdata[PIX_W-1:0];
        REG_TOL:    tol_q    <= pwdata[TOL_W-1:0];
        REG_WIDTH:  width_q  <= pwdata[CFG_DIM_W-1:0];
        REG_HEIGHT: height_q <= pwdata[CFG_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FORMAT: prdata = APB_DW'(fmt_q);
      REG_KEY:    prdata = APB_DW'(key_q);
      REG_TOL:    prdata = APB_DW'(tol_q);
      REG_WIDTH:  prdata = APB_DW'(width_q);
      REG_HEIGHT: prdata = APB_DW'(height_q);
      default:    prdata = '0;
    endcase
  end

  assign match_cfg = '{fmt: fmt_q, key: key_q, tol: tol_q};
  assign dims      = '{width: width_q, height: height_q};

  ckmb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (match_cfg),
    .pix_valid_i (s_axis_tvalid),
    .pix_ready_o (s_axis_tready),
    .pix_data_i  (s_axis_tdata),
    .q_valid_o   (fq_valid),
    .q_ready_i   (fq_ready),
    .q_match_o   (fq_match)
  );

  ckmb_fifo #(
    .WIDTH (1)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_match),
    .pop_valid_o  (bq_valid),
    .pop_ready_i  (bq_ready),
    .pop_data_o   (bq_match)
  );

  ckmb_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dims_i      (dims),
    .q_valid_i   (bq_valid),
    .q_ready_o   (bq_ready),
    .q_match_i   (bq_match),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tlast = res.frame_done;
  assign m_axis_tdata = {6'b0, res.box_bottom, res.box_right, res.box_top,
                         res.box_left, res.box_empty, res.mask_bit};

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Testbench for color_key_mask_bbox_top: pixel frames in, mask bits and box reports checked.

module tb;
  import ckmb_pkg::*;

  localparam int unsigned LIMIT_CYC = 600000;
  localparam logic [FMT_W-1:0] FMT_NONE = 2'd3;

  typedef enum int {PIX_RANDOM, PIX_EXACT, PIX_NEAR, PIX_MISS} pix_kind_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic [PIX_W-1:0]    s_axis_tdata = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [OUT_DW-1:0]   m_axis_tdata;
  logic                m_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  color_key_mask_bbox_top DUT (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // register shadow, reset values
  logic [FMT_W-1:0]     cfg_fmt = FMT_RGBA;
  logic [PIX_W-1:0]     cfg_key = '0;
  logic [TOL_W-1:0]     cfg_tol = '0;
  logic [CFG_DIM_W-1:0] cfg_w = 13'd1;
  logic [CFG_DIM_W-1:0] cfg_h = 13'd1;

  // frame tracking state
  int unsigned col_cnt = 0, row_cnt = 0;
  int unsigned min_col = 'hFFF, min_row = 'hFFF, max_col = 0, max_row = 0;
  bit          any_hit = 1'b0;

  logic [PIX_W-1:0] pixel_q[$];
  result_t          mask_box_q[$];

  int unsigned err_cnt = 0;
  int unsigned cyc_cnt = 0;
  bit          pix_taken = 1'b0;

  function automatic bit chan_ok(logic [7:0] p, logic [7:0] k);
    int lo, hi;
    lo = int'(k) - int'(cfg_tol);
    hi = int'(k) + int'(cfg_tol);
    return (int'(p) >= lo) && (int'(p) <= hi);
  endfunction

  function automatic bit key_hit(logic [PIX_W-1:0] pix);
    case (cfg_fmt)
      FMT_RGBA:  return chan_ok(pix[7:0], cfg_key[7:0]) && chan_ok(pix[15:8], cfg_key[15:8]) &&
                        chan_ok(pix[23:16], cfg_key[23:16]) &&
                        chan_ok(pix[31:24], cfg_key[31:24]);
      FMT_GRAY:  return chan_ok(pix[7:0], cfg_key[7:0]) && chan_ok(pix[15:8], cfg_key[15:8]);
      FMT_INDEX: return chan_ok(pix[7:0], cfg_key[7:0]);
      default:   return 1'b0;
    endcase
  endfunction

  function automatic int unsigned dim_used(logic [CFG_DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM_DEF) return MAX_DIM_DEF;
    return 32'(d);
  endfunction

  function automatic void frame_restart();
    col_cnt = 0;
    row_cnt = 0;
    min_col = 'hFFF;
    min_row = 'hFFF;
    max_col = 0;
    max_row = 0;
    any_hit = 1'b0;
  endfunction

  // mask bit for one pixel, plus the box report when it closes the frame
  function automatic result_t track_pixel(logic [PIX_W-1:0] pix);
    result_t     r;
    bit          hit, row_end, last;
    int unsigned w, h;
    r = '0;
    w = dim_used(cfg_w);
    h = dim_used(cfg_h);
    hit = key_hit(pix);
    // counters left over from a wider/taller setting end the row or frame at once
    row_end = (col_cnt + 1 >= w);
    last = row_end && (row_cnt + 1 >= h);
    if (hit) begin
      if (!any_hit || col_cnt < min_col) min_col = col_cnt;
      if (!any_hit || row_cnt < min_row) min_row = row_cnt;
      if (!any_hit || col_cnt > max_col) max_col = col_cnt;
      if (!any_hit || row_cnt > max_row) max_row = row_cnt;
      any_hit = 1'b1;
    end
    r.mask_bit = hit;
    if (last) begin
      r.frame_done = 1'b1;
      if (any_hit) begin
        r.box_left = min_col[BOX_W-1:0];
        r.box_top = min_row[BOX_W-1:0];
        r.box_right = max_col[BOX_W-1:0];
        r.box_bottom = max_row[BOX_W-1:0];
      end else begin
        r.box_empty = 1'b1;
      end
      frame_restart();
    end else if (row_end) begin
      col_cnt = 0;
      row_cnt++;
    end else begin
      col_cnt++;
    end
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  // pixel built around the current key; unused bits always random
  function automatic logic [PIX_W-1:0] pixel_for(pix_kind_e kind);
    logic [PIX_W-1:0] p;
    int               chans, off;
    p = $urandom;
    chans = (cfg_fmt == FMT_GRAY) ? 2 : (cfg_fmt == FMT_INDEX) ? 1 : 4;
    if (kind != PIX_RANDOM) begin
      for (int c = 0; c < chans; c++) begin
        off = (kind == PIX_NEAR) ?
              int'($urandom_range(0, 2 * cfg_tol + 4)) - int'(cfg_tol) - 2 : 0;
        p[8*c +: 8] = cfg_key[8*c +: 8] + off[7:0];
      end
      if (kind == PIX_MISS) p[$urandom_range(0, 8 * chans - 1)] ^= 1'b1;
    end
    return p;
  endfunction

  // monitor: check the result beat first, then predict the pixel beat of the same edge
  always @(posedge clk_i) begin : mon
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (mask_box_q.size() == 0) begin
        $error("result beat with nothing expected");
        err_cnt++;
      end else begin
        want = mask_box_q.pop_front();
        check_field("mask_bit", want.mask_bit, m_axis_tdata[0]);
        check_field("frame_done", want.frame_done, m_axis_tlast);
        check_field("box_empty", want.box_empty, m_axis_tdata[1]);
        check_field("box_left", want.box_left, m_axis_tdata[13:2]);
        check_field("box_top", want.box_top, m_axis_tdata[25:14]);
        check_field("box_right", want.box_right, m_axis_tdata[37:26]);
        check_field("box_bottom", want.box_bottom, m_axis_tdata[49:38]);
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      mask_box_q.push_back(track_pixel(pixel_q.pop_front()));
    pix_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > LIMIT_CYC) begin
      $display("color_key_mask_bbox_top test failed");
      $finish;
    end
  end

  // pixel driver: bursts of beats with random gaps
  int unsigned burst_left = 0, gap_left = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !pix_taken) begin
      // beat still waiting for tready
    end else if (gap_left > 0) begin
      s_axis_tvalid <= 1'b0;
      gap_left--;
    end else if (pixel_q.size() > 0) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= pixel_q[0];
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 40);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // result sink: tready follows a rotating pattern, replaced now and then
  logic [31:0] rdy_pat = '1;
  logic [4:0]  rdy_pos = '0;
  int unsigned rdy_left = 0;

  always @(negedge clk_i) begin
    if (rdy_left == 0) begin
      rdy_left = $urandom_range(16, 200);
      rdy_pat = ($urandom_range(0, 3) == 0) ? '1 : ($urandom | 32'h1111_1111);
    end else begin
      rdy_left--;
    end
    m_axis_tready <= rdy_pat[rdy_pos];
    rdy_pos <= rdy_pos + 1'b1;
  end

  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_FORMAT: cfg_fmt = val[FMT_W-1:0];
      REG_KEY:    cfg_key = val;
      REG_TOL:    cfg_tol = val[TOL_W-1:0];
      REG_WIDTH:  cfg_w = val[CFG_DIM_W-1:0];
      REG_HEIGHT: cfg_h = val[CFG_DIM_W-1:0];
      default:    ;
    endcase
  endtask

  task automatic wait_idle();
    while (pixel_q.size() != 0 || mask_box_q.size() != 0 || s_axis_tvalid)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [CFG_DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return CFG_DIM_W'($urandom_range(MAX_DIM_DEF + 1, 8191));
      2:       return CFG_DIM_W'(MAX_DIM_DEF);
      default: return CFG_DIM_W'($urandom_range(1, 8));
    endcase
  endfunction

  initial begin : stim
    int unsigned rnd_items, n, area, r;
    rnd_items = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: 1x1 frames, key 0, exact match
    pixel_q.push_back(32'h0000_0000);
    pixel_q.push_back(32'h0000_0001);
    pixel_q.push_back(32'hFFFF_FFFF);
    wait_idle();

    // RGBA, 3x2, channel bounds at exactly +/- tolerance and one past
    apb_write(REG_FORMAT, APB_DW'(FMT_RGBA));
    apb_write(REG_KEY, 32'h80FF_1000);
    apb_write(REG_TOL, 32'h10);
    apb_write(REG_WIDTH, 3);
    apb_write(REG_HEIGHT, 2);
    pixel_q.push_back(32'h70EF_2010);
    pixel_q.push_back(32'h6FFF_1000);
    pixel_q.push_back(32'h90FF_0000);
    pixel_q.push_back(32'h80FF_1011);
    pixel_q.push_back(32'h80FF_2100);
    pixel_q.push_back(32'h91FF_1000);
    wait_idle();

    // gray+alpha, upper bits of key and pixel ignored
    apb_write(REG_FORMAT, APB_DW'(FMT_GRAY));
    apb_write(REG_KEY, 32'hFFFF_40C0);
    apb_write(REG_TOL, 5);
    pixel_q.push_back(32'hAAAA_40C0);
    pixel_q.push_back(32'h0000_45BB);
    pixel_q.push_back(32'h0000_46C0);
    pixel_q.push_back(32'h5555_3BC5);
    pixel_q.push_back(32'h0000_40C6);
    pixel_q.push_back(32'h0000_3AC0);
    wait_idle();

    // index with lower bound clamped at zero; width 0 acts as 1
    apb_write(REG_FORMAT, APB_DW'(FMT_INDEX));
    apb_write(REG_KEY, 32'hFFFF_FF03);
    apb_write(REG_TOL, 10);
    apb_write(REG_WIDTH, 0);
    apb_write(REG_HEIGHT, 3);
    pixel_q.push_back(32'hFFFF_FF00);
    pixel_q.push_back(32'h0000_000E);
    pixel_q.push_back(32'h0000_000D);
    wait_idle();

    // unknown format never matches, even at full tolerance
    apb_write(REG_FORMAT, APB_DW'(FMT_NONE));
    apb_write(REG_TOL, 255);
    apb_write(REG_HEIGHT, 1);
    pixel_q.push_back(32'h0000_0000);
    wait_idle();

    // 8191 wide clamps to the max and keeps the row open; narrowing then closes it
    apb_write(REG_FORMAT, APB_DW'(FMT_INDEX));
    apb_write(REG_KEY, $urandom);
    apb_write(REG_TOL, 0);
    apb_write(REG_WIDTH, 8191);
    apb_write(REG_HEIGHT, 1);
    for (int i = 0; i < 40; i++)
      pixel_q.push_back(pixel_for((i == 7 || i == 39) ? PIX_EXACT : PIX_MISS));
    wait_idle();
    apb_write(REG_WIDTH, 3);
    pixel_q.push_back(pixel_for(PIX_MISS));
    wait_idle();

    // 8191 tall column, then a short height ends the frame on the next row
    apb_write(REG_FORMAT, APB_DW'(FMT_RGBA));
    apb_write(REG_KEY, $urandom);
    apb_write(REG_WIDTH, 0);
    apb_write(REG_HEIGHT, 8191);
    for (int i = 0; i < 40; i++)
      pixel_q.push_back(pixel_for((i == 10 || i == 39) ? PIX_EXACT : PIX_MISS));
    wait_idle();
    apb_write(REG_HEIGHT, 2);
    pixel_q.push_back(pixel_for(PIX_MISS));
    wait_idle();

    // random settings; partial frames leave counters running into the next setting
    while (rnd_items < 1200) begin
      if ($urandom_range(0, 1))
        apb_write(REG_FORMAT, ($urandom_range(0, 9) == 0) ? APB_DW'(FMT_NONE) :
                                                            APB_DW'($urandom_range(0, 2)));
      if ($urandom_range(0, 1)) apb_write(REG_KEY, $urandom);
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 5))
          0:       apb_write(REG_TOL, 0);
          1:       apb_write(REG_TOL, 255);
          default: apb_write(REG_TOL, $urandom_range(0, 40));
        endcase
      end
      if ($urandom_range(0, 1)) apb_write(REG_WIDTH, APB_DW'(pick_dim()));
      if ($urandom_range(0, 1)) apb_write(REG_HEIGHT, APB_DW'(pick_dim()));
      area = dim_used(cfg_w) * dim_used(cfg_h);
      if (area <= 64 && $urandom_range(0, 4) != 0) n = area * $urandom_range(1, 4);
      else n = $urandom_range(1, 30);
      repeat (n) begin
        r = $urandom_range(0, 19);
        pixel_q.push_back(pixel_for(r < 3 ? PIX_RANDOM : r < 6 ? PIX_EXACT :
                                    r < 17 ? PIX_NEAR : PIX_MISS));
      end
      rnd_items += n;
      wait_idle();
    end

    repeat (8) @(negedge clk_i);
    if (err_cnt == 0)
      $display("color_key_mask_bbox_top test passed");
    else
      $display("color_key_mask_bbox_top test failed");
    $finish;
  end

endmodule

// ===== color_key_mask_bbox_top.f =====
src/ckmb_pkg.sv
src/ckmb_front.sv
src/ckmb_fifo.sv
src/ckmb_back.sv
src/color_key_mask_bbox_top.sv
verif/tb.sv
